// ===== rtl/tmrld_pkg.sv =====
// shared types, constants and glyph table for the tile map run-length decoder
package tmrld_pkg;

  localparam int BYTE_W       = 8;
  localparam int REPS_W       = 5;
  localparam int CODE_W       = 3;
  localparam int BYTES_READ_W = 24;
  localparam int SKIP_W       = 16;
  localparam int ROW_W        = 8;
  localparam int CFG_INDEX_W  = 8;
  localparam int CFG_DATA_W   = 16;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

  localparam logic [CFG_INDEX_W-1:0] REG_SKIP_COUNT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH = 8'd1;

  localparam logic [ROW_W-1:0]  ROW_LENGTH_RESET = 8'd64;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR     = 8'd10;

  typedef enum logic [0:0] {
    CMD_RUN = 1'b0,
    CMD_END = 1'b1
  } cmd_kind_t;

  // one decoded map byte handed from front to back
  typedef struct packed {
    cmd_kind_t                kind;
    logic                     clear_row;
    logic [REPS_W-1:0]        reps;
    logic [CODE_W-1:0]        code;
    logic [BYTES_READ_W-1:0]  tally;
  } cmd_t;

  function automatic logic [BYTE_W-1:0] glyph(input logic [CODE_W-1:0] code);
    logic [BYTE_W-1:0] ch;
    unique case (code)
      3'd0:    ch = 8'h7E; // ~
      3'd1:    ch = 8'h2E; // .
      3'd2:    ch = 8'h2A; // *
      3'd3:    ch = 8'h5E; // ^
      3'd4:    ch = 8'h48; // H
      3'd5:    ch = 8'h74; // t
      3'd6:    ch = 8'h3D; // =
      default: ch = 8'h58; // X
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/tmrld_front.sv =====
// front end: takes map bytes, tracks skip, tally and finished state, queues commands
module tmrld_front #(
  parameter int COUNT_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [tmrld_pkg::BYTE_W-1:0]  in_byte,
  input  logic                          first_of_map,
  input  logic [tmrld_pkg::SKIP_W-1:0]  skip_count,
  output logic                          push,
  output tmrld_pkg::cmd_t               push_cmd
);
  import tmrld_pkg::*;

  logic [SKIP_W-1:0]       skip_left, skip_left_next;
  logic                    finished, finished_next;
  logic [COUNT_BITS-1:0]   byte_tally, byte_tally_next;
  logic                    clear_pending, clear_pending_next;

  logic [SKIP_W-1:0]       skip_eff;
  logic                    finished_eff;
  logic [COUNT_BITS-1:0]   tally_eff;
  logic                    clear_eff;
  logic [COUNT_BITS+BYTES_READ_W-1:0] tally_ext;

  always_comb begin
    skip_eff     = first_of_map ? skip_count : skip_left;
    finished_eff = first_of_map ? 1'b0 : finished;
    tally_eff    = first_of_map ? '0 : byte_tally;
    clear_eff    = first_of_map | clear_pending;
    tally_ext    = {{BYTES_READ_W{1'b0}}, tally_eff};

    skip_left_next     = skip_left;
    finished_next      = finished;
    byte_tally_next    = byte_tally;
    clear_pending_next = clear_pending;
    push               = 1'b0;
    push_cmd.kind      = CMD_RUN;
    push_cmd.clear_row = clear_eff;
    push_cmd.reps      = in_byte[BYTE_W-1:CODE_W];
    push_cmd.code      = in_byte[CODE_W-1:0];
    push_cmd.tally     = tally_ext[BYTES_READ_W-1:0];

    if (accept) begin
      skip_left_next     = skip_eff;
      finished_next      = finished_eff;
      byte_tally_next    = tally_eff;
      clear_pending_next = clear_eff;
      if (!finished_eff) begin
        if (skip_eff != '0) begin
          skip_left_next = skip_eff - 1'b1;
        end else if (in_byte == '0) begin
          finished_next      = 1'b1;
          push               = 1'b1;
          push_cmd.kind      = CMD_END;
          clear_pending_next = 1'b0;
        end else begin
          if (tally_eff != {COUNT_BITS{1'b1}}) begin
            byte_tally_next = tally_eff + 1'b1;
          end
          // a zero count is tallied but gives nothing to the back end
          if (in_byte[BYTE_W-1:CODE_W] != '0) begin
            push               = 1'b1;
            clear_pending_next = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_left     <= '0;
      finished      <= 1'b0;
      byte_tally    <= '0;
      clear_pending <= 1'b0;
    end else begin
      skip_left     <= skip_left_next;
      finished      <= finished_next;
      byte_tally    <= byte_tally_next;
      clear_pending <= clear_pending_next;
    end
  end

endmodule

// ===== rtl/tmrld_fifo.sv =====
// short command queue between front and back
module tmrld_fifo (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tmrld_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output tmrld_pkg::cmd_t  pop_cmd,
  output logic             empty
);
  import tmrld_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   fill;

  assign full    = (fill == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + (QUEUE_PTR_W+1)'(push && !full) - (QUEUE_PTR_W+1)'(pop && !empty);
    end
  end

endmodule

// ===== rtl/tmrld_back.sv =====
// back end: expands queued runs into glyphs and newlines, holds the output register
module tmrld_back (
  input  logic                               clk,
  input  logic                               rst,
  input  tmrld_pkg::cmd_t                    cmd,
  input  logic                               cmd_empty,
  output logic                               cmd_pop,
  input  logic [tmrld_pkg::ROW_W-1:0]        row_length,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tmrld_pkg::BYTE_W+tmrld_pkg::BYTES_READ_W-1:0] m_tdata,
  output logic                               m_tlast,
  output logic                               m_tuser
);
  import tmrld_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_GLYPH   = 4'b0010,
    ST_NEWLINE = 4'b0100,
    ST_END     = 4'b1000
  } state_t;

  state_t                 state, state_next;
  logic [REPS_W-1:0]      reps, reps_next;
  logic [CODE_W-1:0]      code, code_next;
  logic [BYTES_READ_W-1:0] tally, tally_next;
  logic [ROW_W-1:0]       row_pos, row_pos_next;

  logic                   out_free;
  logic                   load;
  logic [BYTE_W-1:0]      ch_next;
  logic                   last_next;
  logic                   end_next;
  logic [BYTES_READ_W-1:0] count_next;
  logic [ROW_W:0]         pos_inc;
  logic                   wrap;

  assign out_free = !m_tvalid || m_tready;
  assign pos_inc  = {1'b0, row_pos} + 1'b1;
  // a row length of zero wraps after every glyph
  assign wrap     = (pos_inc >= {1'b0, row_length});

  always_comb begin
    state_next   = state;
    reps_next    = reps;
    code_next    = code;
    tally_next   = tally;
    row_pos_next = row_pos;
    cmd_pop      = 1'b0;
    load         = 1'b0;
    ch_next      = '0;
    last_next    = 1'b0;
    end_next     = 1'b0;
    count_next   = '0;

    unique case (state)
      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          reps_next  = cmd.reps;
          code_next  = cmd.code;
          tally_next = cmd.tally;
          if (cmd.clear_row) begin
            row_pos_next = '0;
          end
          state_next = (cmd.kind == CMD_END) ? ST_END : ST_GLYPH;
        end
      end
      ST_GLYPH: begin
        if (out_free) begin
          load      = 1'b1;
          ch_next   = glyph(code);
          reps_next = reps - 1'b1;
          last_next = (reps == REPS_W'(1)) && !wrap;
          if (wrap) begin
            row_pos_next = '0;
            state_next   = ST_NEWLINE;
          end else begin
            row_pos_next = pos_inc[ROW_W-1:0];
            state_next   = (reps == REPS_W'(1)) ? ST_IDLE : ST_GLYPH;
          end
        end
      end
      ST_NEWLINE: begin
        if (out_free) begin
          load       = 1'b1;
          ch_next    = NEWLINE_CHAR;
          last_next  = (reps == '0);
          state_next = (reps == '0) ? ST_IDLE : ST_GLYPH;
        end
      end
      ST_END: begin
        if (out_free) begin
          load       = 1'b1;
          last_next  = 1'b1;
          end_next   = 1'b1;
          count_next = tally;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      row_pos  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state   <= state_next;
      row_pos <= row_pos_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    reps  <= reps_next;
    code  <= code_next;
    tally <= tally_next;
    if (load) begin
      m_tdata <= {count_next, ch_next};
      m_tlast <= last_next;
      m_tuser <= end_next;
    end
  end

endmodule

// ===== rtl/tile_map_run_length_decoder.sv =====
// top level of the tile map run-length decoder: config registers and front/queue/back
// Each map byte is accepted by the front end while the queue has room; the front end
// handles the skip window, the byte tally and the terminator, and passes one command
// per run or end into a four-deep queue. The back end fetches a command and then
// puts out one character per cycle while m_tready does not stall the output;
// skipped bytes, zero counts and bytes after the terminator cost nothing downstream.
// Sustained throughput is set by the back end's one-character-per-cycle output
// register under the same back-pressure. Configuration writes are always taken and
// should be made while the block is idle.
module tile_map_run_length_decoder #(
  parameter int COUNT_BITS = 24
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [7:0] in_byte
  input  logic        s_tuser,    // [0] first_of_map
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // [7:0] out_char, [31:8] bytes_read
  output logic        m_tlast,    // last
  output logic        m_tuser,    // [0] end_of_map
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import tmrld_pkg::*;

  logic [SKIP_W-1:0] skip_count;
  logic [ROW_W-1:0]  row_length;

  logic  q_full, q_empty, q_push, q_pop;
  cmd_t  q_push_cmd, q_pop_cmd;
  logic  accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_count <= '0;
      row_length <= ROW_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SKIP_COUNT) begin
        skip_count <= cfg_data[SKIP_W-1:0];
      end else if (cfg_index == REG_ROW_LENGTH) begin
        row_length <= cfg_data[ROW_W-1:0];
      end
    end
  end

  tmrld_front #(
    .COUNT_BITS (COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_byte      (s_tdata),
    .first_of_map (s_tuser),
    .skip_count   (skip_count),
    .push         (q_push),
    .push_cmd     (q_push_cmd)
  );

  tmrld_fifo u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (q_pop_cmd),
    .empty    (q_empty)
  );

  tmrld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd        (q_pop_cmd),
    .cmd_empty  (q_empty),
    .cmd_pop    (q_pop),
    .row_length (row_length),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule

// ===== tb/sv/tile_map_run_length_decoder_tb.sv =====
// self-checking testbench for the tile map run-length decoder
module tile_map_run_length_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmrld_pkg::*;

  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_BYTES  = 320;

  typedef struct {
    logic [7:0]  ch;
    logic        last;
    logic        eom;
    logic [23:0] count;
  } char_beat_t;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN,
    READY_SPARSE
  } ready_mode_t;

  class map_char_scoreboard;
    logic [15:0] skip_count = '0;
    logic [7:0]  row_length = ROW_LENGTH_RESET;
    logic [15:0] skip_left  = '0;
    int unsigned row_pos    = 0;
    bit          finished   = 1'b0;
    logic [23:0] tally      = '0;
    char_beat_t  pending_chars[$];
    int unsigned mismatches, glyphs, newlines, map_ends, bytes_in, bytes_ignored;

    function logic [7:0] tile_char(logic [2:0] code);
      case (code)
        3'd0: return "~";
        3'd1: return ".";
        3'd2: return "*";
        3'd3: return "^";
        3'd4: return "H";
        3'd5: return "t";
        3'd6: return "=";
        default: return "X";
      endcase
    endfunction

    function void set_reg(logic [7:0] idx, logic [15:0] val);
      if (idx == REG_SKIP_COUNT) skip_count = val;
      else if (idx == REG_ROW_LENGTH) row_length = val[7:0];
    endfunction

    function void take_map_byte(logic [7:0] b, logic first);
      int n;
      char_beat_t beat;
      n = 0;
      bytes_in++;
      if (first) begin
        skip_left = skip_count;
        row_pos   = 0;
        finished  = 1'b0;
        tally     = '0;
      end
      if (finished || skip_left != 0) begin
        if (!finished) skip_left--;
        bytes_ignored++;
        return;
      end
      if (b == 8'h00) begin
        finished = 1'b1;
        beat = '{8'h00, 1'b1, 1'b1, tally};
        pending_chars.push_back(beat);
        map_ends++;
        return;
      end
      if (tally != '1) tally++;
      for (int i = 0; i < int'(b[7:3]); i++) begin
        beat = '{tile_char(b[2:0]), 1'b0, 1'b0, 24'd0};
        pending_chars.push_back(beat);
        glyphs++;
        n++;
        row_pos++;
        // a row length of zero behaves as one
        if (row_pos >= row_length) begin
          beat = '{NEWLINE_CHAR, 1'b0, 1'b0, 24'd0};
          pending_chars.push_back(beat);
          newlines++;
          n++;
          row_pos = 0;
        end
      end
      if (n > 0) pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    function void flag(string why, char_beat_t want, char_beat_t got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t mismatch (%s): expected ch=%h last=%b eom=%b count=%0d, %s",
                 $realtime, why, want.ch, want.last, want.eom, want.count,
                 $sformatf("got ch=%h last=%b eom=%b count=%0d",
                           got.ch, got.last, got.eom, got.count));
    endfunction

    function void check_char(char_beat_t got);
      char_beat_t want;
      if (pending_chars.size() == 0) begin
        want = '{8'h00, 1'b0, 1'b0, 24'd0};
        flag("no beat expected", want, got);
        return;
      end
      want = pending_chars.pop_front();
      if (got.ch !== want.ch || got.last !== want.last || got.eom !== want.eom ||
          got.count !== want.count)
        flag("field", want, got);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;
  logic        s_tuser   = 1'b0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  map_char_scoreboard board;
  char_beat_t  seen;
  int          burst_left  = 0;
  int          cur_skip    = 0;
  int          settings    = 0;
  int          cycle_count = 0;
  ready_mode_t ready_mode  = READY_ALWAYS;
  int          mode_left   = 0;
  logic [3:0]  tick        = '0;
  localparam logic [15:0] READY_SHAPE = 16'b1011_0110_1110_0101;

  tile_map_run_length_decoder #(.COUNT_BITS(24)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped after %0d cycles with %0d beats outstanding",
               cycle_count, board.pending_chars.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // output backpressure: a randomly chosen ready mode, re-picked when its countdown runs out
  always @(posedge clk) begin
    tick <= tick + 4'd1;
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 3));
      mode_left  <= $urandom_range(50, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS:  m_tready <= 1'b1;
      READY_RANDOM:  m_tready <= ($urandom_range(0, 3) != 0);
      READY_PATTERN: m_tready <= READY_SHAPE[tick];
      default:       m_tready <= (tick[2:0] == 3'd0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen.ch    = m_tdata[7:0];
      seen.count = m_tdata[31:8];
      seen.last  = m_tlast;
      seen.eom   = m_tuser;
      board.check_char(seen);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tuser  <= first;
    do @(posedge clk); while (!s_tready);
    board.take_map_byte(b, first);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (board.pending_chars.size() != 0) @(posedge clk);
    // skipped or zero-count bytes may still be in flight with nothing expected
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_reg(idx, val);
    if (idx == REG_SKIP_COUNT) cur_skip = val;
    settings++;
  endtask

  function automatic logic [7:0] run_byte();
    int unsigned pick;
    logic [4:0]  reps;
    pick = $urandom_range(0, 9);
    if (pick < 5) reps = 5'($urandom_range(1, 4));
    else if (pick < 9) reps = 5'($urandom_range(5, 15));
    else reps = 5'($urandom_range(16, 31));
    if ($urandom_range(0, 15) == 0) reps = 5'd0;
    return {reps, 3'($urandom_range(0, 7))};
  endfunction

  // start marker, skipped bytes, data bytes, usually a terminator, then trailing bytes
  task automatic random_map(input int n_data, input bit noisy);
    int         total;
    logic       first;
    logic [7:0] b;
    total = cur_skip + n_data;
    for (int i = 0; i < total; i++) begin
      first = (i == 0);
      b = (i < cur_skip) ? 8'($urandom_range(0, 255)) : run_byte();
      if (noisy && $urandom_range(0, 24) == 0) begin
        first = 1'($urandom_range(0, 1));
        b     = 8'($urandom);
      end
      send_byte(b, first);
    end
    if ($urandom_range(0, 7) != 0) send_byte(8'h00, total == 0);
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom), 1'b0);
  endtask

  initial begin
    int          base;
    logic [15:0] row;
    board = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers, no start marker: every tile code, full runs, zero count
    for (int c = 0; c < 8; c++) send_byte({5'd1, 3'(c)}, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    // skipped zero byte, single-glyph rows
    write_reg(REG_SKIP_COUNT, 16'd2);
    write_reg(REG_ROW_LENGTH, 16'd1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h00, 1'b0);

    // widest row, then shrink it below the current position, then zero
    write_reg(REG_SKIP_COUNT, 16'd0);
    write_reg(REG_ROW_LENGTH, 16'd255);
    send_byte(8'h0A, 1'b1);
    send_byte(8'hFB, 1'b0);
    write_reg(REG_ROW_LENGTH, 16'd10);
    send_byte(8'h1C, 1'b0);
    write_reg(REG_ROW_LENGTH, 16'd0);
    send_byte(8'h1D, 1'b0);
    send_byte(8'h00, 1'b0);

    // longest skip window: every byte sent falls inside it
    write_reg(REG_SKIP_COUNT, 16'hFFFF);
    write_reg(REG_ROW_LENGTH, 16'd64);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h3A, 1'b0);

    base = board.bytes_in;
    while (board.bytes_in - base < RANDOM_BYTES) begin
      write_reg(REG_SKIP_COUNT,
                ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 5)));
      case ($urandom_range(0, 4))
        0:       row = 16'd1;
        1:       row = 16'd255;
        default: row = 16'($urandom_range(2, 80));
      endcase
      write_reg(REG_ROW_LENGTH, row);
      random_map($urandom_range(1, 12), 1'b1);
      // hold the sender until the output side has caught up
      drain_results();
      repeat ($urandom_range(1, 4)) random_map($urandom_range(1, 12), 1'b1);
    end

    drain_results();
    $display("%0d input beats (%0d ignored) over %0d register writes", board.bytes_in,
             board.bytes_ignored, settings);
    $display("%0d glyphs, %0d newlines, %0d map ends, %0d mismatches", board.glyphs,
             board.newlines, board.map_ends, board.mismatches);
    if (board.mismatches == 0 && board.pending_chars.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== tile_map_run_length_decoder.f =====
rtl/tmrld_pkg.sv
rtl/tmrld_front.sv
rtl/tmrld_fifo.sv
rtl/tmrld_back.sv
rtl/tile_map_run_length_decoder.sv
tb/sv/tile_map_run_length_decoder_tb.sv
